/* rtl/lsts_pkg.sv */
// package for the least slack time scheduler
// status codes, opcodes, configuration indexes and reset constants; no dependencies
package lsts_pkg;
  localparam int TASKS_DEF = 8;
  localparam logic [2:0] ST_FREE = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_SLEEPING = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;
  localparam logic [2:0] OP_SCHED = 3'd0;
  localparam logic [2:0] OP_SETRT = 3'd1;
  localparam logic [2:0] OP_WAIT = 3'd2;
  localparam logic [2:0] OP_BLOCK = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;
  localparam logic [2:0] OP_FREE = 3'd5;
  localparam logic CFG_OVERHEAD = 1'b0;
  localparam logic CFG_MAX_SLICE = 1'b1;
  localparam logic [15:0] OVERHEAD_RST = 16'd500;
  localparam logic [31:0] MAX_SLICE_RST = 32'd16384;
  localparam logic [15:0] UTIL_MAX = 16'hFFFF;
  localparam logic [6:0] PCT = 7'd100;
  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } lsts_div_req_t;
endpackage

/* rtl/lsts_divider.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on lsts_pkg
module lsts_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lsts_pkg::lsts_div_req_t req,
  output logic                   busy,
  output logic [63:0]            quot
);
  import lsts_pkg::*;
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0] cnt_r, cnt_nxt;
  logic [32:0] sh;
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    sh = {rem_r[31:0], q_r[63]};
    if (req.start) begin
      q_nxt = req.dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = sh - {1'b0, dvs_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end
  assign busy = (cnt_r != 7'd0);
  assign quot = q_r;
endmodule

/* rtl/least_slack_time_scheduler_top.sv */
// least slack time scheduler, top level; uses lsts_pkg and lsts_divider
// schedule: update, pick and slice-limit walks over all entries; the round-robin pass runs only with no rt pick
// set rt params: two 64-step divisions in the shared divider
// other requests: one item at a time, ready again only once the previous result has been taken
// result held in an output register; reset clears all entries at once
// synchronous active-low reset
module least_slack_time_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [2:0]  in_task_req,
  input  logic [31:0] in_now,
  input  logic [31:0] in_period,
  input  logic [30:0] in_rel_deadline,
  input  logic [31:0] in_exec_budget,
  input  logic [1:0]  in_wait_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_chosen,
  output logic        out_chosen_valid,
  output logic [31:0] out_slice,
  output logic [15:0] out_utilization,
  output logic        out_deadline_miss,
  output logic        out_bad_request,
  output logic [2:0]  out_task_state,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import lsts_pkg::*;
  localparam int TASKS = TASKS_DEF;
  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [IW-1:0] LAST = IW'(TASKS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD = 4'd1;
  localparam logic [3:0] S_PICK = 4'd2;
  localparam logic [3:0] S_RR = 4'd3;
  localparam logic [3:0] S_DYN = 4'd4;
  localparam logic [3:0] S_FIN = 4'd5;
  localparam logic [3:0] S_DIV1 = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_RTFIN = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_WAIT1 = 4'd10;
  localparam logic [3:0] S_WAIT2 = 4'd11;
  localparam logic [3:0] S_PUSH = 4'd12;

  logic [3:0] state_r;
  logic [15:0] ovh_r;
  logic [31:0] maxs_r;
  logic is_rt_r [TASKS];
  logic [2:0] stat_r [TASKS];
  logic [1:0] wait_r [TASKS];
  logic [31:0] rdy_r [TASKS];
  logic [31:0] per_r [TASKS];
  logic [30:0] dl_r [TASKS];
  logic [31:0] bud_r [TASKS];
  logic [32:0] rem_r [TASKS];
  logic [31:0] slk_r [TASKS];
  logic [31:0] rs_r [TASKS];
  logic [15:0] tu_r [TASKS];
  logic [15:0] usum_r;
  logic [IW-1:0] rr_r;
  logic [31:0] last_r;

  logic [2:0] op_r, req_r;
  logic [31:0] now_r, t_r, per_in_r, bud_in_r;
  logic [30:0] dl_in_r;
  logic [1:0] wk_r;
  logic [IW-1:0] i_r, best_r;
  logic best_ok_r, miss_r, cp_ok_r, sl_ok_r;
  logic [31:0] cp_r, sl_r, s_r;
  logic [IW:0] n_r;
  logic [31:0] q1_r;

  logic req_ok;
  logic [IW-1:0] k;
  assign req_ok = ({29'd0, req_r} < 32'(TASKS));
  assign k = req_ok ? req_r[IW-1:0] : '0;

  lsts_div_req_t dreq;
  logic dbusy;
  logic [63:0] dq;
  lsts_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dq));

  // per-entry combinational helpers for the entry under the walk index
  logic [31:0] end_i, el_i;
  logic signed [33:0] r_i;
  assign end_i = rdy_r[i_r] + per_r[i_r];
  assign el_i = now_r - rs_r[i_r];
  assign r_i = $signed({1'b0, rem_r[i_r]}) - $signed({2'b0, el_i});

  function automatic logic [31:0] slack_f(input logic [31:0] rdy, input logic [30:0] dl,
                                          input logic [32:0] rem, input logic [31:0] t);
    logic [31:0] d;
    logic signed [33:0] sd, df;
    d = rdy + {1'b0, dl} - t;
    sd = {{2{d[31]}}, d};
    df = sd - $signed({1'b0, rem});
    return (df < 0) ? 32'd0 : df[31:0];
  endfunction

  logic [IW-1:0] rr_n;
  assign rr_n = (rr_r >= LAST) ? '0 : rr_r + 1'b1;

  logic [15:0] u_sat;
  logic [31:0] rt_ceil;

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = '0;
    dreq.divisor = per_in_r;
    if (state_r == S_IDLE && in_valid && in_opcode == OP_SETRT && in_period != 32'd0) begin
      dreq.start = 1'b1;
      dreq.dividend = {32'd0, in_now};
      dreq.divisor = in_period;
    end else if (state_r == S_DIV1 && !dbusy) begin
      dreq.start = 1'b1;
      dreq.dividend = {32'd0, bud_in_r} * 64'(PCT);
    end
  end

  assign u_sat = (dq + 64'd1 > 64'(UTIL_MAX)) ? UTIL_MAX : dq[15:0] + 16'd1;
  assign rt_ceil = q1_r * per_in_r;

  assign in_ready = (state_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    logic [15:0] us;
    logic [16:0] ua;
    logic [31:0] sv;
    logic [32:0] rm;
    logic [36:0] rm10;
    logic [2:0] st;
    logic [31:0] en;
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovh_r <= OVERHEAD_RST;
      maxs_r <= MAX_SLICE_RST;
      usum_r <= '0;
      rr_r <= '0;
      last_r <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < TASKS; j++) begin
        is_rt_r[j] <= 1'b0; stat_r[j] <= ST_FREE; wait_r[j] <= '0;
        rdy_r[j] <= '0; per_r[j] <= '0; dl_r[j] <= '0; bud_r[j] <= '0;
        rem_r[j] <= '0; slk_r[j] <= '0; rs_r[j] <= '0; tu_r[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OVERHEAD) ovh_r <= cfg_data[15:0];
        else maxs_r <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= in_opcode; req_r <= in_task_req; now_r <= in_now;
            t_r <= in_now + {16'd0, ovh_r};
            per_in_r <= in_period; dl_in_r <= in_rel_deadline;
            bud_in_r <= in_exec_budget; wk_r <= in_wait_kind;
            i_r <= '0; miss_r <= 1'b0; best_ok_r <= 1'b0;
            cp_ok_r <= 1'b0; sl_ok_r <= 1'b0;
            out_chosen <= '0; out_chosen_valid <= 1'b0;
            out_deadline_miss <= 1'b0; out_bad_request <= 1'b0;
            if (in_opcode == OP_SCHED) state_r <= S_UPD;
            else if (in_opcode == OP_SETRT && in_period != 32'd0
                     && {29'd0, in_task_req} < 32'(TASKS)) state_r <= S_WAIT1;
            else state_r <= S_FIN;
          end
        end
        S_UPD: begin
          st = stat_r[i_r];
          if (!is_rt_r[i_r] || st == ST_FREE || st == ST_BLOCKED) begin
            if (st == ST_RUNNING && wait_r[i_r] == 2'd0) stat_r[i_r] <= ST_READY;
          end else begin
            rm = rem_r[i_r];
            sv = slk_r[i_r];
            if (st == ST_RUNNING) begin
              if (r_i <= 0) begin
                rm = '0; st = ST_SLEEPING;
                sv = slack_f(rdy_r[i_r], dl_r[i_r], 33'd0, t_r);
              end else begin
                rm = r_i[32:0]; st = ST_READY;
              end
              // rm above a tenth of the budget, tested as 10*rm against the budget
              rm10 = ({4'd0, rm} << 3) + ({4'd0, rm} << 1);
              if (wait_r[i_r] == 2'd0 && sv == 32'd0 &&
                  rm10 > {5'd0, bud_r[i_r]}) miss_r <= 1'b1;
            end
            en = rdy_r[i_r];
            if (t_r >= end_i) begin
              en = end_i; rm = {1'b0, bud_r[i_r]}; st = ST_READY;
            end
            if (st != ST_SLEEPING) sv = slack_f(en, dl_r[i_r], rm, t_r);
            rdy_r[i_r] <= en; rem_r[i_r] <= rm; stat_r[i_r] <= st; slk_r[i_r] <= sv;
          end
          i_r <= (i_r == LAST) ? '0 : i_r + 1'b1;
          if (i_r == LAST) state_r <= S_PICK;
        end
        S_PICK: begin
          if (is_rt_r[i_r] && stat_r[i_r] == ST_READY && wait_r[i_r] == 2'd0 &&
              (!best_ok_r || slk_r[i_r] < slk_r[best_r])) begin
            best_r <= i_r; best_ok_r <= 1'b1;
          end
          i_r <= (i_r == LAST) ? '0 : i_r + 1'b1;
          n_r <= '0;
          if (i_r == LAST) state_r <= S_RR;
        end
        S_RR: begin
          if (best_ok_r) begin
            state_r <= S_DYN;
            s_r <= is_rt_r[best_r] ? rem_r[best_r][31:0] : maxs_r;
          end else if (n_r == (IW+1)'(TASKS)) begin
            state_r <= S_DYN;
          end else begin
            rr_r <= rr_n;
            n_r <= n_r + 1'b1;
            if (stat_r[rr_n] == ST_READY && wait_r[rr_n] == 2'd0) begin
              best_r <= rr_n; best_ok_r <= 1'b1;
              s_r <= is_rt_r[rr_n] ? rem_r[rr_n][31:0] : maxs_r;
              state_r <= S_DYN;
            end
          end
        end
        S_DYN: begin
          if (is_rt_r[i_r] && !(best_ok_r && i_r == best_r)) begin
            if (stat_r[i_r] == ST_SLEEPING || wait_r[i_r] != 2'd0) begin
              if (!cp_ok_r || end_i < cp_r) begin cp_r <= end_i; cp_ok_r <= 1'b1; end
            end else if (best_ok_r && slk_r[best_r] > 32'd0 &&
                         (!sl_ok_r || slk_r[i_r] < sl_r)) begin
              sl_r <= slk_r[i_r]; sl_ok_r <= 1'b1;
            end
          end
          i_r <= (i_r == LAST) ? '0 : i_r + 1'b1;
          if (i_r == LAST) state_r <= S_OUT;
        end
        S_OUT: begin
          out_deadline_miss <= miss_r;
          if (best_ok_r) begin
            sv = s_r;
            if (sl_ok_r && sl_r != 32'd0 && sl_r < sv) sv = sl_r;
            if (cp_ok_r && (cp_r - t_r) < sv) sv = cp_r - t_r;
            last_r <= sv;
            stat_r[best_r] <= ST_RUNNING;
            if (is_rt_r[best_r]) rs_r[best_r] <= now_r;
            out_chosen <= 3'(best_r);
            out_chosen_valid <= 1'b1;
          end else begin
            last_r <= cp_ok_r ? cp_r - t_r : maxs_r;
          end
          req_r <= 3'd0;
          state_r <= S_FIN;
          if (!req_ok) state_r <= S_FIN;
        end
        S_WAIT1: state_r <= S_DIV1;
        S_DIV1: begin
          if (!dbusy) begin
            q1_r <= dq[31:0];
            state_r <= S_WAIT2;
          end
        end
        S_WAIT2: state_r <= S_DIV2;
        S_DIV2: if (!dbusy) state_r <= S_RTFIN;
        S_RTFIN: begin
          us = usum_r;
          per_r[k] <= per_in_r; dl_r[k] <= dl_in_r; bud_r[k] <= bud_in_r;
          if (!is_rt_r[k]) begin
            rdy_r[k] <= (rt_ceil < now_r) ? rt_ceil + per_in_r : rt_ceil;
            stat_r[k] <= ST_READY;
            rem_r[k] <= {1'b0, bud_in_r};
            is_rt_r[k] <= 1'b1;
          end else begin
            us = (us > tu_r[k]) ? us - tu_r[k] : 16'd0;
          end
          tu_r[k] <= u_sat;
          ua = {1'b0, us} + {1'b0, u_sat};
          usum_r <= ua[16] ? UTIL_MAX : ua[15:0];
          state_r <= S_FIN;
          op_r <= OP_SCHED;
        end
        S_FIN: begin
          if (op_r == OP_SCHED) begin
          end else if (op_r > OP_FREE || !req_ok) begin
            out_bad_request <= 1'b1;
          end else begin
            case (op_r)
              OP_SETRT: out_bad_request <= 1'b1;
              OP_WAIT: wait_r[k] <= wk_r;
              OP_BLOCK: stat_r[k] <= ST_BLOCKED;
              OP_RELEASE: stat_r[k] <= ST_READY;
              OP_FREE: begin
                if (is_rt_r[k]) usum_r <= (usum_r > tu_r[k]) ? usum_r - tu_r[k] : 16'd0;
                is_rt_r[k] <= 1'b0; stat_r[k] <= ST_FREE; wait_r[k] <= '0;
                rdy_r[k] <= '0; per_r[k] <= '0; dl_r[k] <= '0; bud_r[k] <= '0;
                rem_r[k] <= '0; slk_r[k] <= '0; rs_r[k] <= '0; tu_r[k] <= '0;
              end
              default: out_bad_request <= 1'b1;
            endcase
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_slice = last_r;
  assign out_utilization = usum_r;
  // req_r is cleared after a schedule, so keep the request in a separate register
  logic [2:0] oreq_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_ready) oreq_r <= in_task_req;
  end
  assign out_task_state = ({29'd0, oreq_r} < 32'(TASKS)) ? stat_r[oreq_r[IW-1:0]] : 3'd0;
endmodule
